/* sv/cubic_least_squares_fit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cubic least-squares fit block.
// ----------------------------------------------------------------------------
`ifndef CUBIC_LEAST_SQUARES_FIT_ASSERT_SVH
`define CUBIC_LEAST_SQUARES_FIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLSF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLSF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/clsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsf_pkg
// Shared constants, types and fixed-point helpers of the cubic fit block.
// ----------------------------------------------------------------------------
package clsf_pkg;

  localparam int GRID_SIZE = 32;
  localparam int FRAC_BITS = 32;
  localparam int WORD_W    = 64;
  localparam int HALF_W    = WORD_W / 2;
  localparam int DBL_W     = 2 * WORD_W;
  localparam int NTERMS    = 4;
  localparam int NCOLS     = NTERMS + 1;
  localparam int NPOW      = 2 * NTERMS - 1;
  localparam int PSUM_W    = 36;
  localparam int MSUM_W    = 26;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 5;
  localparam int OPC_W     = 2;
  localparam int COEF_BASE = NTERMS * NCOLS;
  localparam int MEM_DEPTH = COEF_BASE + NTERMS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [OPC_W-1:0] OP_ADD_POINT = 2'd0;
  localparam logic [OPC_W-1:0] OP_QUERY     = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR     = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] Q_LIMIT = {1'b0, {(WORD_W-1){1'b1}}} >> FRAC_BITS;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    word_t   a;
    word_t   b;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } alu_rsp_t;

  typedef enum logic [1:0] {AS_IDLE, AS_MUL, AS_DIV, AS_FIN} alu_state_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ACC, ST_LOAD,
    ST_SW_RD1, ST_SW_RD2, ST_SW_CMP, ST_SWP_A, ST_SWP_B, ST_SWP_W, ST_SWP_W2,
    ST_EL_PIV, ST_EL_PIV2, ST_EL_KRD, ST_EL_DIV, ST_EL_DIVW, ST_EL_JRD,
    ST_EL_MUL, ST_EL_MULW, ST_EL_SUB, ST_EL_SUBW,
    ST_BS_RD, ST_BS_ACC, ST_BS_JRD, ST_BS_JRD2, ST_BS_MUL, ST_BS_MULW,
    ST_BS_SUB, ST_BS_SUBW, ST_BS_PRD, ST_BS_DIV, ST_BS_DIVW,
    ST_FAIL, ST_QCHK, ST_Q_V0, ST_Q_RD, ST_Q_GO, ST_Q_WAIT, ST_Q_FIN
  } state_t;

  function automatic logic [WORD_W-1:0] mag_of(word_t v);
    logic [WORD_W-1:0] u;
    u = v;
    return v[WORD_W-1] ? (~u + 1'b1) : u;
  endfunction

  // Saturate a magnitude with an overflow flag back into the signed range.
  function automatic word_t from_mag(logic neg, logic hi_nz, logic [WORD_W-1:0] lo);
    word_t r;
    if (hi_nz || lo[WORD_W-1]) begin
      r = neg ? Q_MIN : Q_MAX;
    end else begin
      r = neg ? word_t'(~lo + 1'b1) : word_t'(lo);
    end
    return r;
  endfunction

  function automatic word_t to_q(logic [PSUM_W-1:0] v);
    logic [WORD_W-1:0] w;
    w = WORD_W'(v);
    return (w > Q_LIMIT) ? Q_MAX : word_t'(w << FRAC_BITS);
  endfunction

  function automatic logic [ADDR_W-1:0] mat_addr(logic [1:0] r, logic [2:0] c);
    return ADDR_W'(int'(r) * NCOLS + int'(c));
  endfunction

  function automatic logic [ADDR_W-1:0] coef_addr(logic [1:0] idx);
    return ADDR_W'(COEF_BASE + int'(idx));
  endfunction

endpackage

/* sv/clsf_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsf_alu
// Shared fixed-point unit: saturating add and subtract, multiply
// from four 32x32 partial products, and a restoring divide of one bit a cycle.
// ----------------------------------------------------------------------------
module clsf_alu (
  input  logic              clk,
  input  logic              rst,
  input  clsf_pkg::alu_req_t req,
  output clsf_pkg::alu_rsp_t rsp
);
  import clsf_pkg::*;

  localparam int CNT_W  = $clog2(DBL_W);
  localparam int NPARTS = 4;

  alu_state_t        state, state_next;
  alu_op_t           op_q;
  logic [WORD_W-1:0] ma, mb;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [DBL_W-1:0]  acc;
  logic [WORD_W-1:0] prod;
  logic [1:0]        pshift;
  logic [DBL_W-1:0]  num, quo;
  logic [WORD_W-1:0] rem;

  logic signed [WORD_W:0] sum;
  word_t                  sat_sum;
  logic [HALF_W-1:0]      ah, bh;
  logic [WORD_W-1:0]      pp;
  logic [DBL_W-1:0]       shifted;
  logic [WORD_W:0]        rem_sh;
  logic                   ge;
  word_t                  fin_val;

  always_comb begin
    if (req.op == ALU_SUB) begin
      sum = {req.a[WORD_W-1], req.a} - {req.b[WORD_W-1], req.b};
    end else begin
      sum = {req.a[WORD_W-1], req.a} + {req.b[WORD_W-1], req.b};
    end
    if (sum[WORD_W] != sum[WORD_W-1]) begin
      sat_sum = sum[WORD_W] ? Q_MIN : Q_MAX;
    end else begin
      sat_sum = sum[WORD_W-1:0];
    end
  end

  assign ah = cnt[1] ? ma[WORD_W-1:HALF_W] : ma[HALF_W-1:0];
  assign bh = cnt[0] ? mb[WORD_W-1:HALF_W] : mb[HALF_W-1:0];
  assign pp = ah * bh;

  always_comb begin
    case (pshift)
      2'd0:    shifted = DBL_W'(prod);
      2'd1:    shifted = DBL_W'(prod) << HALF_W;
      default: shifted = DBL_W'(prod) << WORD_W;
    endcase
  end

  assign rem_sh = {rem, num[DBL_W-1]};
  assign ge     = rem_sh >= {1'b0, mb};

  always_comb begin
    if (op_q == ALU_MUL) begin
      fin_val = from_mag(neg, |acc[DBL_W-1:WORD_W+FRAC_BITS],
                         acc[WORD_W+FRAC_BITS-1:FRAC_BITS]);
    end else begin
      fin_val = from_mag(neg, |quo[DBL_W-1:WORD_W], quo[WORD_W-1:0]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      AS_IDLE: begin
        if (req.start && req.op == ALU_MUL) state_next = AS_MUL;
        if (req.start && req.op == ALU_DIV) state_next = AS_DIV;
      end
      AS_MUL: if (cnt == CNT_W'(NPARTS)) state_next = AS_FIN;
      AS_DIV: if (cnt == CNT_W'(DBL_W - 1)) state_next = AS_FIN;
      AS_FIN: state_next = AS_IDLE;
      default: state_next = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= AS_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= (state == AS_FIN) ||
                  (state == AS_IDLE && req.start &&
                   (req.op == ALU_ADD || req.op == ALU_SUB));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      AS_IDLE: begin
        if (req.start) begin
          op_q <= req.op;
          ma   <= mag_of(req.a);
          mb   <= mag_of(req.b);
          neg  <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
          cnt  <= '0;
          acc  <= '0;
          rem  <= '0;
          quo  <= '0;
          num  <= DBL_W'(mag_of(req.a)) << FRAC_BITS;
          rsp.result <= sat_sum;
        end
      end
      AS_MUL: begin
        if (cnt < CNT_W'(NPARTS)) begin
          prod   <= pp;
          pshift <= 2'(cnt[0]) + 2'(cnt[1]);
        end
        if (cnt != '0) acc <= acc + shifted;
        cnt <= cnt + 1'b1;
      end
      AS_DIV: begin
        rem <= ge ? WORD_W'(rem_sh - {1'b0, mb}) : rem_sh[WORD_W-1:0];
        quo <= {quo[DBL_W-2:0], ge};
        num <= {num[DBL_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      AS_FIN: rsp.result <= fin_val;
      default: ;
    endcase
  end

endmodule

/* sv/cubic_least_squares_fit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_least_squares_fit
// Accumulates power sums of grid points, solves the cubic normal equations by
// Gaussian elimination in Q31.32 and evaluates the fit at queried rows.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Direction
//  command   start, busy, opcode, point_row,       in (busy out)
//            point_col
//  result    done, query_row, mark_col, mark_valid out
//
// An add-point word keeps busy high while it accumulates one power term per cycle.
// Clear and the unused opcode finish in the accept cycle.
// A query on a solved fit keeps busy high through six multiplies
// and three adds in the shared unit; a query that must solve first also runs
// the elimination, whose length depends on row swaps and is dominated
// by ten divides in the shared unit.
// Reset is synchronous and clears all sums and the fit status.
// The result word is shown on done for one cycle and cannot be stalled.
`include "cubic_least_squares_fit_assert.svh"

module cubic_least_squares_fit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [clsf_pkg::OPC_W-1:0]  opcode,
  input  logic [clsf_pkg::ROW_W-1:0]  point_row,
  input  logic [clsf_pkg::COL_W-1:0]  point_col,
  output logic                        done,
  output logic [clsf_pkg::ROW_W-1:0]  query_row,
  output logic [clsf_pkg::COL_W-1:0]  mark_col,
  output logic                        mark_valid
);
  import clsf_pkg::*;

  localparam logic [2:0] RHS_COL = 3'(NTERMS);
  localparam logic [3:0] Q_LAST  = 4'd8;

  state_t state, state_next;
  logic [1:0] ci, ci_next, ck, ck_next;
  logic [2:0] cj, cj_next;
  logic [3:0] qs, qs_next;

  logic [PSUM_W-1:0] power_sums [NPOW];
  logic [MSUM_W-1:0] moment_sums [NTERMS];
  logic              fit_solved, fit_failed;

  logic [OPC_W-1:0]  op_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [PSUM_W-1:0] p;
  word_t opa, opb, acc, f, piv, v, t, r2, rd_q;

  word_t             mem [MEM_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, rd_addr;
  word_t             mem_wd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic              accept, emit, emit_valid;
  logic [COL_W-1:0]  emit_col;
  logic [2:0]        pidx;
  word_t             load_val, r_val;
  logic [WORD_W-1:0] c_u, vm;
  logic              row_out;

  clsf_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign r_val   = to_q(PSUM_W'(row_q));
  assign row_out = 32'(row_q) >= 32'(GRID_SIZE);
  assign pidx    = (cj == RHS_COL) ? 3'd0 : 3'(ci) + cj;
  assign load_val = (cj == RHS_COL) ? to_q(PSUM_W'(moment_sums[ci])) :
                                      to_q(power_sums[pidx]);
  assign c_u     = v >> FRAC_BITS;
  assign vm      = mag_of(v) >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    ci_next    = ci;
    ck_next    = ck;
    cj_next    = cj;
    qs_next    = qs;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    rd_addr    = '0;
    alu_req    = '0;
    emit       = 1'b0;
    emit_valid = 1'b0;
    emit_col   = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_ADD_POINT) begin
          cj_next    = '0;
          state_next = ST_ACC;
        end else if (accept && opcode == OP_QUERY) begin
          ci_next    = '0;
          cj_next    = '0;
          state_next = fit_solved ? ST_QCHK : ST_LOAD;
        end
      end
      ST_ACC: begin
        cj_next = cj + 1'b1;
        if (cj == 3'(NPOW - 1)) state_next = ST_IDLE;
      end
      ST_LOAD: begin
        mem_we = 1'b1;
        mem_wa = mat_addr(ci, cj);
        mem_wd = load_val;
        if (cj == RHS_COL) begin
          cj_next = '0;
          ci_next = ci + 1'b1;
          if (ci == 2'(NTERMS - 1)) begin
            ci_next    = '0;
            ck_next    = 2'd1;
            state_next = ST_SW_RD1;
          end
        end else begin
          cj_next = cj + 1'b1;
        end
      end
      // Pairwise row swap pass ahead of elimination.
      ST_SW_RD1: begin
        rd_addr    = mat_addr(ci, 3'(ci));
        state_next = ST_SW_RD2;
      end
      ST_SW_RD2: begin
        rd_addr    = mat_addr(ck, 3'(ci));
        state_next = ST_SW_CMP;
      end
      ST_SW_CMP, ST_SWP_W2: begin
        if (state == ST_SWP_W2) begin
          mem_we = 1'b1;
          mem_wa = mat_addr(ck, cj);
          mem_wd = opa;
        end
        if (state == ST_SW_CMP && opa < rd_q) begin
          cj_next    = '0;
          state_next = ST_SWP_A;
        end else if (state == ST_SWP_W2 && cj != RHS_COL) begin
          cj_next    = cj + 1'b1;
          state_next = ST_SWP_A;
        end else if (ck == 2'(NTERMS - 1)) begin
          if (ci == 2'(NTERMS - 2)) begin
            ci_next    = '0;
            state_next = ST_EL_PIV;
          end else begin
            ci_next    = ci + 1'b1;
            ck_next    = ci + 2'd2;
            state_next = ST_SW_RD1;
          end
        end else begin
          ck_next    = ck + 1'b1;
          state_next = ST_SW_RD1;
        end
      end
      ST_SWP_A: begin
        rd_addr    = mat_addr(ci, cj);
        state_next = ST_SWP_B;
      end
      ST_SWP_B: begin
        rd_addr    = mat_addr(ck, cj);
        state_next = ST_SWP_W;
      end
      ST_SWP_W: begin
        mem_we     = 1'b1;
        mem_wa     = mat_addr(ci, cj);
        mem_wd     = rd_q;
        state_next = ST_SWP_W2;
      end
      // Forward elimination below each pivot.
      ST_EL_PIV: begin
        rd_addr    = mat_addr(ci, 3'(ci));
        state_next = ST_EL_PIV2;
      end
      ST_EL_PIV2: begin
        ck_next    = ci + 1'b1;
        state_next = (rd_q == '0) ? ST_FAIL : ST_EL_KRD;
      end
      ST_EL_KRD: begin
        rd_addr    = mat_addr(ck, 3'(ci));
        state_next = ST_EL_DIV;
      end
      ST_EL_DIV: begin
        alu_req    = '{start: 1'b1, op: ALU_DIV, a: rd_q, b: piv};
        state_next = ST_EL_DIVW;
      end
      ST_EL_DIVW: begin
        cj_next = '0;
        if (alu_rsp.done) state_next = ST_EL_JRD;
      end
      ST_EL_JRD: begin
        rd_addr    = mat_addr(ci, cj);
        state_next = ST_EL_MUL;
      end
      ST_EL_MUL: begin
        alu_req    = '{start: 1'b1, op: ALU_MUL, a: f, b: rd_q};
        state_next = ST_EL_MULW;
      end
      ST_EL_MULW: begin
        rd_addr = mat_addr(ck, cj);
        if (alu_rsp.done) state_next = ST_EL_SUB;
      end
      ST_EL_SUB: begin
        alu_req    = '{start: 1'b1, op: ALU_SUB, a: rd_q, b: opb};
        state_next = ST_EL_SUBW;
      end
      ST_EL_SUBW: begin
        if (alu_rsp.done) begin
          mem_we = 1'b1;
          mem_wa = mat_addr(ck, cj);
          mem_wd = alu_rsp.result;
          if (cj != RHS_COL) begin
            cj_next    = cj + 1'b1;
            state_next = ST_EL_JRD;
          end else if (ck != 2'(NTERMS - 1)) begin
            ck_next    = ck + 1'b1;
            state_next = ST_EL_KRD;
          end else if (ci != 2'(NTERMS - 2)) begin
            ci_next    = ci + 1'b1;
            state_next = ST_EL_PIV;
          end else begin
            ci_next    = 2'(NTERMS - 1);
            state_next = ST_BS_RD;
          end
        end
      end
      // Back substitution from the last row up.
      ST_BS_RD: begin
        rd_addr    = mat_addr(ci, RHS_COL);
        state_next = ST_BS_ACC;
      end
      ST_BS_ACC: begin
        cj_next    = 3'(ci) + 3'd1;
        state_next = (ci == 2'(NTERMS - 1)) ? ST_BS_PRD : ST_BS_JRD;
      end
      ST_BS_JRD: begin
        rd_addr    = mat_addr(ci, cj);
        state_next = ST_BS_JRD2;
      end
      ST_BS_JRD2: begin
        rd_addr    = coef_addr(cj[1:0]);
        state_next = ST_BS_MUL;
      end
      ST_BS_MUL: begin
        alu_req    = '{start: 1'b1, op: ALU_MUL, a: opa, b: rd_q};
        state_next = ST_BS_MULW;
      end
      ST_BS_MULW: if (alu_rsp.done) state_next = ST_BS_SUB;
      ST_BS_SUB: begin
        alu_req    = '{start: 1'b1, op: ALU_SUB, a: acc, b: opb};
        state_next = ST_BS_SUBW;
      end
      ST_BS_SUBW: begin
        if (alu_rsp.done) begin
          cj_next    = cj + 1'b1;
          state_next = (cj == 3'(NTERMS - 1)) ? ST_BS_PRD : ST_BS_JRD;
        end
      end
      ST_BS_PRD: begin
        rd_addr    = mat_addr(ci, 3'(ci));
        state_next = ST_BS_DIV;
      end
      ST_BS_DIV: begin
        alu_req    = '{start: (rd_q != '0), op: ALU_DIV, a: acc, b: rd_q};
        state_next = (rd_q == '0) ? ST_FAIL : ST_BS_DIVW;
      end
      ST_BS_DIVW: begin
        if (alu_rsp.done) begin
          mem_we     = 1'b1;
          mem_wa     = coef_addr(ci);
          mem_wd     = alu_rsp.result;
          ci_next    = ci - 1'b1;
          state_next = (ci == '0) ? ST_QCHK : ST_BS_RD;
        end
      end
      ST_FAIL: state_next = ST_QCHK;
      ST_QCHK: begin
        rd_addr = coef_addr(2'd0);
        qs_next = '0;
        if (fit_failed || row_out) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_Q_V0;
        end
      end
      ST_Q_V0: state_next = ST_Q_RD;
      ST_Q_RD: begin
        case (qs)
          4'd0:    rd_addr = coef_addr(2'd1);
          4'd2:    rd_addr = coef_addr(2'd2);
          default: rd_addr = coef_addr(2'd3);
        endcase
        state_next = ST_Q_GO;
      end
      // Horner-free evaluation in the original order: c0 + c1*r +
      // (c2*r)*r + (c3*r2)*r, each step through the shared unit.
      ST_Q_GO: begin
        case (qs)
          4'd0, 4'd2: alu_req = '{start: 1'b1, op: ALU_MUL, a: rd_q, b: r_val};
          4'd3, 4'd7: alu_req = '{start: 1'b1, op: ALU_MUL, a: t, b: r_val};
          4'd5:       alu_req = '{start: 1'b1, op: ALU_MUL, a: r_val, b: r_val};
          4'd6:       alu_req = '{start: 1'b1, op: ALU_MUL, a: rd_q, b: r2};
          default:    alu_req = '{start: 1'b1, op: ALU_ADD, a: v, b: t};
        endcase
        state_next = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (alu_rsp.done) begin
          qs_next    = qs + 1'b1;
          state_next = (qs == Q_LAST) ? ST_Q_FIN : ST_Q_RD;
        end
      end
      ST_Q_FIN: begin
        emit = 1'b1;
        if (!v[WORD_W-1]) begin
          emit_valid = c_u <= WORD_W'(GRID_SIZE - 1);
          emit_col   = c_u[COL_W-1:0];
        end else begin
          emit_valid = (vm == '0);
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ci         <= '0;
      ck         <= '0;
      cj         <= '0;
      qs         <= '0;
      fit_solved <= 1'b0;
      fit_failed <= 1'b0;
      done       <= 1'b0;
      for (int i = 0; i < NPOW; i++) power_sums[i] <= '0;
      for (int i = 0; i < NTERMS; i++) moment_sums[i] <= '0;
    end else begin
      state <= state_next;
      ci    <= ci_next;
      ck    <= ck_next;
      cj    <= cj_next;
      qs    <= qs_next;
      done  <= emit;
      if (state == ST_IDLE && accept && opcode == OP_CLEAR) begin
        fit_solved <= 1'b0;
        fit_failed <= 1'b0;
        for (int i = 0; i < NPOW; i++) power_sums[i] <= '0;
        for (int i = 0; i < NTERMS; i++) moment_sums[i] <= '0;
      end
      if (state == ST_IDLE && accept && opcode == OP_QUERY && !fit_solved) begin
        fit_failed <= 1'b0;
      end
      if (state == ST_ACC) begin
        power_sums[cj] <= power_sums[cj] + p;
        if (cj < 3'(NTERMS)) begin
          moment_sums[cj[1:0]] <= moment_sums[cj[1:0]] +
                                  MSUM_W'(p[MSUM_W-1:0] * col_q);
        end
        if (cj == 3'(NPOW - 1)) fit_solved <= 1'b0;
      end
      if (state == ST_FAIL) begin
        fit_failed <= 1'b1;
        fit_solved <= 1'b1;
      end
      if (state == ST_BS_DIVW && alu_rsp.done && ci == '0) fit_solved <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= opcode;
      row_q <= point_row;
      col_q <= point_col;
      p     <= PSUM_W'(1);
    end
    if (state == ST_ACC) p <= PSUM_W'(p * row_q);
    if (emit) begin
      query_row  <= row_q;
      mark_col   <= emit_valid ? emit_col : '0;
      mark_valid <= emit_valid;
    end
    case (state)
      ST_SW_RD2, ST_SWP_B, ST_BS_JRD2: opa <= rd_q;
      ST_EL_PIV2: piv <= rd_q;
      ST_EL_DIVW: if (alu_rsp.done) f <= alu_rsp.result;
      ST_EL_MULW, ST_BS_MULW: if (alu_rsp.done) opb <= alu_rsp.result;
      ST_BS_ACC: acc <= rd_q;
      ST_BS_SUBW: if (alu_rsp.done) acc <= alu_rsp.result;
      ST_Q_V0: v <= rd_q;
      ST_Q_WAIT: begin
        if (alu_rsp.done) begin
          case (qs)
            4'd1, 4'd4, 4'd8: v <= alu_rsp.result;
            4'd5:             r2 <= alu_rsp.result;
            default:          t <= alu_rsp.result;
          endcase
        end
      end
      default: ;
    endcase
  end

  // A result word only follows a query word.
  `CLSF_ASSERT_IMP(a_done_after_busy, clk, rst, done,
    $past(busy) && $past(op_q) == OP_QUERY, "result word without a query in progress")
  `CLSF_ASSERT_NXT(a_add_goes_busy, clk, rst, accept && opcode == OP_ADD_POINT,
    busy, "add-point word did not start accumulation")
  `CLSF_ASSERT_IMP(a_valid_needs_fit, clk, rst, done && mark_valid,
    fit_solved && !fit_failed, "valid mark without a solved fit")

endmodule
